@@ src/wenp_pkg.sv @@
package wenp_pkg;

   localparam int NODE_COUNT = 8;
   localparam int SIGMOID_TABLE_DEPTH = 256;

   localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SUM_W = 16 + NODE_W;
   localparam int DEN_W = (SUM_W > 18) ? SUM_W : 18;
   localparam int DIV_STEPS = 17;
   localparam int STEP_W = 5;
   localparam int COST_W = 29;
   localparam int SIG_IDX_W = $clog2(SIGMOID_TABLE_DEPTH);

   localparam logic [27:0] COST_MAX = 28'hFFFFFFF;
   localparam logic [15:0] LOAD_THRESHOLD_RESET = 16'd19661;
   localparam logic [15:0] PENALTY_GAIN_RESET = 16'd6554;
   localparam logic [15:0] WEIGHT_RESET = 16'd16384;

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_SLOT = 3'd1;
   localparam logic [2:0] MODE_PREF = 3'd2;
   localparam logic [2:0] MODE_SCHED = 3'd3;
   localparam logic [2:0] MODE_XFER = 3'd4;

   localparam logic REG_LOAD_THRESHOLD = 1'b0;
   localparam logic REG_PENALTY_GAIN = 1'b1;

   localparam logic [15:0] SIG_OFFSET [4] = '{16'd0, 16'd6554, 16'd13107, 16'd19661};

   typedef logic [15:0] sig_rom_type [SIGMOID_TABLE_DEPTH];

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_LOAD, ST_SUM, ST_RCHK, ST_RDIV, ST_RTAKE,
      ST_SIG_IDX, ST_SIG_READ, ST_SIG_SUM, ST_WCHK, ST_WDIV, ST_WTAKE,
      ST_PREF, ST_SPRE, ST_SMUL1, ST_SMUL2, ST_SCAND, ST_TCHK, ST_TDIV,
      ST_TCAND, ST_COMMIT, ST_DONE
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ACC, OP_RATIO_ZERO, OP_DIV_START_RATIO,
      OP_DIV_START_W, OP_DIV_START_T, OP_DIV_STEP, OP_RATIO_TAKE,
      OP_SIG_IDX, OP_SIG_READ, OP_SIG_SUM, OP_W_TAKE, OP_PREF,
      OP_SCHED_PRE, OP_MUL1, OP_MUL2, OP_SCAND, OP_TCAND, OP_COMMIT,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [NODE_W-1:0] node;
      logic [1:0]        wsel;
      logic              idle;
   } dp_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [2:0] mode;
      logic       fits;
      logic       cap_zero;
      logic       sum_zero;
      logic       ssum_zero;
      logic       out_free;
   } dp_status_type;

   // Long division used only while the sigmoid table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [63:0] a);
      logic [63:0] b;
      logic [63:0] term;
      logic [63:0] sum;
      b = a << 10;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int n = 1; n <= 6; n++) begin
         term = udiv64((term * b) >> 30, 64'(n));
         if ((n & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int sq = 0; sq < 4; sq++) begin
         sum = (sum * sum) >> 30;
      end
      return sum;
   endfunction

   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      longint      x;
      logic [63:0] a;
      logic [63:0] e;
      logic [63:0] v;
      for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
         x = -longint'(262144)
             + longint'(udiv64(64'd524288 * 64'(i), 64'(SIGMOID_TABLE_DEPTH)));
         a = (x < 0) ? 64'(-x) : 64'(x);
         e = exp_neg(a);
         if (x < 0) begin
            v = udiv64(e << 16, (64'd1 << 30) + e);
         end else begin
            v = udiv64(64'd1 << 46, (64'd1 << 30) + e);
         end
         rom[i] = v[15:0];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

@@ src/wenp_if.sv @@
interface wenp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  node_index;
   logic [15:0] amount;
   logic [15:0] node_compute_cost;
   logic [15:0] node_retention_cost;
   logic [15:0] request_transfer_cost;
   logic [15:0] request_prep_cost;
   logic [15:0] distance;

   modport source (
      output valid, mode, node_index, amount, node_compute_cost, node_retention_cost,
             request_transfer_cost, request_prep_cost, distance,
      input  ready
   );
   modport sink (
      input  valid, mode, node_index, amount, node_compute_cost, node_retention_cost,
             request_transfer_cost, request_prep_cost, distance,
      output ready
   );
endinterface

interface wenp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  chosen_node;
   logic        found;
   logic [27:0] best_cost;
   logic [7:0]  placed_mask;
   logic [15:0] load_ratio;

   modport source (
      output valid, chosen_node, found, best_cost, placed_mask, load_ratio,
      input  ready
   );
   modport sink (
      input  valid, chosen_node, found, best_cost, placed_mask, load_ratio,
      output ready
   );
endinterface

@@ src/wenp_csr.sv @@
module wenp_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [15:0] load_threshold,
   output logic [15:0] penalty_gain
);
   import wenp_pkg::*;

   logic [15:0] thr_ff, thr_in;
   logic [15:0] gain_ff, gain_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      thr_in = thr_ff;
      gain_in = gain_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LOAD_THRESHOLD: thr_in = pwdata[15:0];
            REG_PENALTY_GAIN:   gain_in = pwdata[15:0];
            default:            thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOAD_THRESHOLD: prdata = {16'd0, thr_ff};
         REG_PENALTY_GAIN:   prdata = {16'd0, gain_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= LOAD_THRESHOLD_RESET;
         gain_ff <= PENALTY_GAIN_RESET;
      end else begin
         thr_ff <= thr_in;
         gain_ff <= gain_in;
      end
   end

   assign load_threshold = thr_ff;
   assign penalty_gain = gain_ff;
endmodule

@@ src/wenp_ctrl.sv @@
module wenp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  wenp_pkg::dp_status_type status,
   output wenp_pkg::dp_cmd_type    cmd
);
   import wenp_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          wsel_ff, wsel_in;
   logic                last_node;
   logic                last_step;

   assign last_node = (node_ff == NODE_W'(NODE_COUNT - 1));
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      node_in = node_ff;
      step_in = step_ff;
      wsel_in = wsel_ff;
      cmd.op = OP_NONE;
      cmd.node = node_ff;
      cmd.wsel = wsel_ff;
      cmd.idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (status.req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            node_in = '0;
            wsel_in = 2'd0;
            if (status.mode == MODE_LOAD) begin
               state_in = ST_LOAD;
            end else if (status.mode == MODE_SLOT) begin
               state_in = ST_SUM;
            end else if (status.mode == MODE_PREF) begin
               state_in = ST_PREF;
            end else if (status.mode == MODE_SCHED) begin
               state_in = ST_SPRE;
            end else if (status.mode == MODE_XFER) begin
               state_in = ST_TCHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            cmd.op = OP_LOAD;
            state_in = ST_DONE;
         end
         ST_SUM: begin
            cmd.op = OP_ACC;
            if (last_node) begin
               state_in = ST_RCHK;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_RCHK: begin
            step_in = '0;
            if (status.sum_zero) begin
               cmd.op = OP_RATIO_ZERO;
               state_in = ST_SIG_IDX;
            end else begin
               cmd.op = OP_DIV_START_RATIO;
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            cmd.op = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_RTAKE;
            end
         end
         ST_RTAKE: begin
            cmd.op = OP_RATIO_TAKE;
            state_in = ST_SIG_IDX;
         end
         ST_SIG_IDX: begin
            cmd.op = OP_SIG_IDX;
            state_in = ST_SIG_READ;
         end
         ST_SIG_READ: begin
            cmd.op = OP_SIG_READ;
            state_in = ST_SIG_SUM;
         end
         ST_SIG_SUM: begin
            cmd.op = OP_SIG_SUM;
            state_in = ST_WCHK;
         end
         ST_WCHK: begin
            step_in = '0;
            if (status.ssum_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_DIV_START_W;
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            cmd.op = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_WTAKE;
            end
         end
         ST_WTAKE: begin
            cmd.op = OP_W_TAKE;
            if (wsel_ff == 2'd3) begin
               state_in = ST_DONE;
            end else begin
               wsel_in = wsel_ff + 1'b1;
               state_in = ST_WCHK;
            end
         end
         ST_PREF: begin
            cmd.op = OP_PREF;
            if (last_node) begin
               state_in = ST_DONE;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_SPRE: begin
            cmd.op = OP_SCHED_PRE;
            state_in = ST_SMUL1;
         end
         ST_SMUL1: begin
            if (status.fits) begin
               cmd.op = OP_MUL1;
               state_in = ST_SMUL2;
            end else if (last_node) begin
               state_in = ST_COMMIT;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_SMUL2: begin
            cmd.op = OP_MUL2;
            state_in = ST_SCAND;
         end
         ST_SCAND: begin
            cmd.op = OP_SCAND;
            if (last_node) begin
               state_in = ST_COMMIT;
            end else begin
               node_in = node_ff + 1'b1;
               state_in = ST_SMUL1;
            end
         end
         ST_TCHK: begin
            step_in = '0;
            if (status.fits) begin
               if (status.cap_zero) begin
                  state_in = ST_TCAND;
               end else begin
                  cmd.op = OP_DIV_START_T;
                  state_in = ST_TDIV;
               end
            end else if (last_node) begin
               state_in = ST_COMMIT;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_TDIV: begin
            cmd.op = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_TCAND;
            end
         end
         ST_TCAND: begin
            cmd.op = OP_TCAND;
            if (last_node) begin
               state_in = ST_COMMIT;
            end else begin
               node_in = node_ff + 1'b1;
               state_in = ST_TCHK;
            end
         end
         ST_COMMIT: begin
            cmd.op = OP_COMMIT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.op = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         node_ff <= '0;
         step_ff <= '0;
         wsel_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         node_ff <= node_in;
         step_ff <= step_in;
         wsel_ff <= wsel_in;
      end
   end
endmodule

@@ src/wenp_datapath.sv @@
module wenp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             load_threshold,
   input  logic [15:0]             penalty_gain,
   input  wenp_pkg::dp_cmd_type     cmd,
   output wenp_pkg::dp_status_type  status,
   wenp_req_if.sink                req,
   wenp_rsp_if.source              rsp
);
   import wenp_pkg::*;

   logic [2:0]  mode_ff, mode_in;
   logic [2:0]  nidx_ff, nidx_in;
   logic [15:0] amt_ff, amt_in;
   logic [15:0] ccost_ff, ccost_in;
   logic [15:0] rcost_ff, rcost_in;
   logic [15:0] tcost_ff, tcost_in;
   logic [15:0] pcost_ff, pcost_in;
   logic [15:0] dist_ff, dist_in;

   logic [15:0] cap_ff [NODE_COUNT];
   logic [15:0] cap_in [NODE_COUNT];
   logic [15:0] used_ff [NODE_COUNT];
   logic [15:0] used_in [NODE_COUNT];
   logic [15:0] comp_ff [NODE_COUNT];
   logic [15:0] comp_in [NODE_COUNT];
   logic [15:0] ret_ff [NODE_COUNT];
   logic [15:0] ret_in [NODE_COUNT];
   logic [NODE_COUNT-1:0] valid_ff, valid_in;
   logic [15:0] w_ff [4];
   logic [15:0] w_in [4];

   logic [SUM_W-1:0]     cap_sum_ff, cap_sum_in;
   logic [SUM_W-1:0]     used_sum_ff, used_sum_in;
   logic [15:0]          ratio_ff, ratio_in;
   logic [SIG_IDX_W-1:0] sidx_ff [4];
   logic [SIG_IDX_W-1:0] sidx_in [4];
   logic [15:0]          s_ff [4];
   logic [15:0]          s_in [4];
   logic [17:0]          ssum_ff, ssum_in;

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [16:0]      quo_ff, quo_in;

   logic [16:0] qfix_ff, qfix_in;
   logic [31:0] p1_ff, p1_in;
   logic [15:0] p2_ff, p2_in;
   logic [27:0] p3_ff, p3_in;

   logic              have_ff, have_in;
   logic [NODE_W-1:0] win_ff, win_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [7:0]        mask_ff, mask_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_chosen_ff, rsp_chosen_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [27:0] rsp_best_ff, rsp_best_in;
   logic [7:0]  rsp_mask_ff, rsp_mask_in;
   logic [15:0] rsp_ratio_ff, rsp_ratio_in;

   logic [NODE_W-1:0] n;
   logic              accept;
   logic              fits_c;
   logic              cap_zero_c;
   logic [15:0]       quo_sat;
   logic              div_ge;
   logic [DEN_W:0]    div_rem;

   assign n = cmd.node;
   assign accept = req.valid && req.ready;
   assign req.ready = cmd.idle;
   assign fits_c = valid_ff[n] && ({1'b0, used_ff[n]} + {1'b0, amt_ff} <= {1'b0, cap_ff[n]});
   assign cap_zero_c = (cap_ff[n] == 16'd0);
   assign quo_sat = quo_ff[16] ? 16'hFFFF : quo_ff[15:0];
   assign div_ge = (rem_ff >= {1'b0, den_ff});
   assign div_rem = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   assign status.req_valid = req.valid;
   assign status.mode = mode_ff;
   assign status.fits = fits_c;
   assign status.cap_zero = cap_zero_c;
   assign status.sum_zero = (cap_sum_ff == '0);
   assign status.ssum_zero = (ssum_ff == 18'd0);
   assign status.out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      logic signed [20:0] x;
      logic signed [20:0] t;
      logic [32:0]        prod;
      logic [13:0]        sh;
      logic [31:0]        pm;
      logic [31:0]        pq2;
      logic [31:0]        pq3;
      logic [47:0]        pw;
      logic [15:0]        rr;
      logic [COST_W-1:0]  c;

      mode_in = mode_ff;
      nidx_in = nidx_ff;
      amt_in = amt_ff;
      ccost_in = ccost_ff;
      rcost_in = rcost_ff;
      tcost_in = tcost_ff;
      pcost_in = pcost_ff;
      dist_in = dist_ff;
      cap_in = cap_ff;
      used_in = used_ff;
      comp_in = comp_ff;
      ret_in = ret_ff;
      valid_in = valid_ff;
      w_in = w_ff;
      cap_sum_in = cap_sum_ff;
      used_sum_in = used_sum_ff;
      ratio_in = ratio_ff;
      sidx_in = sidx_ff;
      s_in = s_ff;
      ssum_in = ssum_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      qfix_in = qfix_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      p3_in = p3_ff;
      have_in = have_ff;
      win_in = win_ff;
      best_in = best_ff;
      mask_in = mask_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_found_in = rsp_found_ff;
      rsp_best_in = rsp_best_ff;
      rsp_mask_in = rsp_mask_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      x = '0;
      t = '0;
      prod = '0;
      sh = '0;
      pm = '0;
      pq2 = '0;
      pq3 = '0;
      pw = '0;
      rr = '0;
      c = '0;

      if (accept) begin
         mode_in = req.mode;
         nidx_in = req.node_index;
         amt_in = req.amount;
         ccost_in = req.node_compute_cost;
         rcost_in = req.node_retention_cost;
         tcost_in = req.request_transfer_cost;
         pcost_in = req.request_prep_cost;
         dist_in = req.distance;
         cap_sum_in = '0;
         used_sum_in = '0;
         ratio_in = 16'd0;
         have_in = 1'b0;
         win_in = '0;
         best_in = '0;
         mask_in = 8'd0;
      end

      case (cmd.op)
         OP_LOAD: begin
            if (int'(nidx_ff) < NODE_COUNT) begin
               cap_in[NODE_W'(nidx_ff)] = amt_ff;
               used_in[NODE_W'(nidx_ff)] = 16'd0;
               comp_in[NODE_W'(nidx_ff)] = ccost_ff;
               ret_in[NODE_W'(nidx_ff)] = rcost_ff;
               valid_in[NODE_W'(nidx_ff)] = 1'b1;
            end
         end
         OP_ACC: begin
            if (valid_ff[n]) begin
               cap_sum_in = cap_sum_ff + SUM_W'(cap_ff[n]);
               used_sum_in = used_sum_ff + SUM_W'(used_ff[n]);
            end
         end
         OP_RATIO_ZERO: begin
            ratio_in = 16'd0;
         end
         OP_DIV_START_RATIO: begin
            rem_in = (DEN_W + 1)'(used_sum_ff);
            den_in = DEN_W'(cap_sum_ff);
            quo_in = 17'd0;
         end
         OP_DIV_START_W: begin
            rem_in = (DEN_W + 1)'(s_ff[cmd.wsel]);
            den_in = DEN_W'(ssum_ff);
            quo_in = 17'd0;
         end
         OP_DIV_START_T: begin
            rem_in = (DEN_W + 1)'(used_ff[n]);
            den_in = DEN_W'(cap_ff[n]);
            quo_in = 17'd0;
         end
         OP_DIV_STEP: begin
            rem_in = {div_rem[DEN_W-1:0], 1'b0};
            quo_in = {quo_ff[15:0], div_ge};
         end
         OP_RATIO_TAKE: begin
            ratio_in = quo_sat;
         end
         OP_SIG_IDX: begin
            for (int k = 0; k < 4; k++) begin
               x = $signed({5'd0, ratio_ff}) - $signed({5'd0, load_threshold})
                   - $signed({5'd0, SIG_OFFSET[k]});
               t = x + 21'sd262144;
               if (t < 0) begin
                  sidx_in[k] = '0;
               end else begin
                  prod = 33'(t[19:0]) * 33'(SIGMOID_TABLE_DEPTH);
                  sh = prod[32:19];
                  if (int'(sh) > SIGMOID_TABLE_DEPTH - 1) begin
                     sidx_in[k] = SIG_IDX_W'(SIGMOID_TABLE_DEPTH - 1);
                  end else begin
                     sidx_in[k] = SIG_IDX_W'(sh);
                  end
               end
            end
         end
         OP_SIG_READ: begin
            for (int k = 0; k < 4; k++) begin
               s_in[k] = SIG_ROM[sidx_ff[k]];
            end
         end
         OP_SIG_SUM: begin
            ssum_in = 18'(s_ff[0]) + 18'(s_ff[1]) + 18'(s_ff[2]) + 18'(s_ff[3]);
         end
         OP_W_TAKE: begin
            w_in[cmd.wsel] = quo_ff[15:0];
         end
         OP_PREF: begin
            if (fits_c) begin
               used_in[n] = used_ff[n] + amt_ff;
               if (int'(n) < 8) begin
                  mask_in[3'(n)] = 1'b1;
               end
            end
         end
         OP_SCHED_PRE: begin
            pq2 = w_ff[2] * tcost_ff;
            pq3 = w_ff[3] * pcost_ff;
            qfix_in = 17'(pq2[31:16]) + 17'(pq3[31:16]);
         end
         OP_MUL1: begin
            p1_in = w_ff[0] * comp_ff[n];
            pm = w_ff[1] * ret_ff[n];
            p2_in = pm[31:16];
         end
         OP_MUL2: begin
            pw = 48'(p1_ff) * 48'(amt_ff);
            p3_in = pw[47:20];
         end
         OP_SCAND: begin
            c = COST_W'(p3_ff) + COST_W'(p2_ff) + COST_W'(qfix_ff);
            if (!have_ff || c < best_ff) begin
               have_in = 1'b1;
               best_in = c;
               win_in = n;
            end
         end
         OP_TCAND: begin
            rr = cap_zero_c ? 16'd0 : quo_sat;
            pm = penalty_gain * rr;
            c = {1'b0, dist_ff, 12'd0} + COST_W'(pm[31:16]);
            if (!have_ff || c < best_ff) begin
               have_in = 1'b1;
               best_in = c;
               win_in = n;
            end
         end
         OP_COMMIT: begin
            if (have_ff) begin
               used_in[win_ff] = used_ff[win_ff] + amt_ff;
            end
         end
         OP_PUBLISH: begin
            rsp_valid_in = 1'b1;
            rsp_chosen_in = have_ff ? 3'(win_ff) : 3'd0;
            rsp_found_in = have_ff;
            if (!have_ff) begin
               rsp_best_in = 28'd0;
            end else if (best_ff[COST_W-1]) begin
               rsp_best_in = COST_MAX;
            end else begin
               rsp_best_in = best_ff[27:0];
            end
            rsp_mask_in = mask_ff;
            rsp_ratio_in = ratio_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            w_ff[k] <= WEIGHT_RESET;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         w_ff <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      nidx_ff <= nidx_in;
      amt_ff <= amt_in;
      ccost_ff <= ccost_in;
      rcost_ff <= rcost_in;
      tcost_ff <= tcost_in;
      pcost_ff <= pcost_in;
      dist_ff <= dist_in;
      cap_ff <= cap_in;
      used_ff <= used_in;
      comp_ff <= comp_in;
      ret_ff <= ret_in;
      cap_sum_ff <= cap_sum_in;
      used_sum_ff <= used_sum_in;
      ratio_ff <= ratio_in;
      sidx_ff <= sidx_in;
      s_ff <= s_in;
      ssum_ff <= ssum_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      qfix_ff <= qfix_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      have_ff <= have_in;
      win_ff <= win_in;
      best_ff <= best_in;
      mask_ff <= mask_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_found_ff <= rsp_found_in;
      rsp_best_ff <= rsp_best_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_ratio_ff <= rsp_ratio_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.chosen_node = rsp_chosen_ff;
   assign rsp.found = rsp_found_ff;
   assign rsp.best_cost = rsp_best_ff;
   assign rsp.placed_mask = rsp_mask_ff;
   assign rsp.load_ratio = rsp_ratio_ff;
endmodule

@@ src/weighted_edge_node_placement.sv @@
// The block handles one item at a time and gives one result item for each. A load item writes
// one node entry, and a prefetch visits every node entry in turn. A schedule item runs the
// multiply and candidate steps for each fitting node and skips the other nodes. All
// divisions share one restoring divider that yields one quotient bit per cycle: a slot start
// divides for one ratio and four weights, each skipped when its divisor is zero, and a
// transfer divides once for each fitting node with a nonzero capacity. A finished result is
// held in an output register, so the next item is taken while it waits.
module weighted_edge_node_placement (
   input  logic        clock,
   input  logic        reset,
   wenp_req_if.sink    req,
   wenp_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import wenp_pkg::*;

   logic [15:0]   load_threshold;
   logic [15:0]   penalty_gain;
   dp_cmd_type    cmd;
   dp_status_type status;

   wenp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .load_threshold (load_threshold),
      .penalty_gain   (penalty_gain)
   );

   wenp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   wenp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .load_threshold (load_threshold),
      .penalty_gain   (penalty_gain),
      .cmd            (cmd),
      .status         (status),
      .req            (req),
      .rsp            (rsp)
   );
endmodule

@@ src/wenp_checker.sv @@
module wenp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_chosen_node,
   input logic        rsp_found,
   input logic [27:0] rsp_best_cost,
   input logic [7:0]  rsp_placed_mask,
   input logic [15:0] rsp_load_ratio
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is at work");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_chosen_node == 3'd0 && rsp_best_cost == 28'd0)
      else $error("result without a node carries a node or cost");

   a_mask_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_placed_mask != 8'd0 |-> !rsp_found && rsp_load_ratio == 16'd0)
      else $error("prefetch result mixes in other fields");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind weighted_edge_node_placement wenp_checker u_wenp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_chosen_node (rsp.chosen_node),
   .rsp_found       (rsp.found),
   .rsp_best_cost   (rsp.best_cost),
   .rsp_placed_mask (rsp.placed_mask),
   .rsp_load_ratio  (rsp.load_ratio)
);

@@ bench/tb_weighted_edge_node_placement.sv @@
module tb_weighted_edge_node_placement;
   timeunit 1ns;
   timeprecision 1ps;

   import wenp_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam logic [2:0] ADDR_LOAD_THRESHOLD = {REG_LOAD_THRESHOLD, 2'b00};
   localparam logic [2:0] ADDR_PENALTY_GAIN = {REG_PENALTY_GAIN, 2'b00};
   localparam logic [2:0] MODE_LAST = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [2:0]  node_index;
      logic [15:0] amount;
      logic [15:0] comp_cost;
      logic [15:0] ret_cost;
      logic [15:0] transfer_cost;
      logic [15:0] prep_cost;
      logic [15:0] distance;
   } request_type;

   typedef struct {
      logic [2:0]  chosen_node;
      logic        found;
      logic [27:0] best_cost;
      logic [7:0]  placed_mask;
      logic [15:0] load_ratio;
   } placement_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   wenp_req_if req ();
   wenp_rsp_if rsp ();

   weighted_edge_node_placement dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req.sink),
      .rsp     (rsp.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state.
   logic [15:0] node_cap [NODE_COUNT];
   logic [15:0] node_fill [NODE_COUNT];
   logic [15:0] node_comp [NODE_COUNT];
   logic [15:0] node_ret [NODE_COUNT];
   logic        node_live [NODE_COUNT];
   logic [15:0] weight [4];
   logic [15:0] centre_offset;
   logic [15:0] usage_gain;
   logic [15:0] sigmoid_table [SIGMOID_TABLE_DEPTH];

   placement_type expected_placements[$];
   int         errors;
   int         items_sent;
   int         items_checked;
   int         mode_counts [8];
   int         found_count;
   int         config_writes;
   bit         no_gaps;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned decay_q30(input longint unsigned a);
      longint unsigned b;
      longint unsigned term;
      longint unsigned acc;
      b = a << 10;
      term = 64'd1 << 30;
      acc = 64'd1 << 30;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * b) >> 30) / longint'(n);
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      for (int k = 0; k < 4; k++) begin
         acc = (acc * acc) >> 30;
      end
      return acc;
   endfunction

   function automatic void fill_sigmoid_table();
      longint          x;
      longint unsigned e;
      longint unsigned v;
      for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
         x = -262144 + longint'((64'd524288 * 64'(i)) / SIGMOID_TABLE_DEPTH);
         e = decay_q30((x < 0) ? 64'(-x) : 64'(x));
         if (x < 0) begin
            v = (e << 16) / ((64'd1 << 30) + e);
         end else begin
            v = (64'd1 << 46) / ((64'd1 << 30) + e);
         end
         sigmoid_table[i] = v[15:0];
      end
   endfunction

   function automatic logic [15:0] sat_ratio(input longint unsigned num,
                                             input longint unsigned den);
      longint unsigned q;
      if (den == 0) begin
         return 16'd0;
      end
      q = (num << 16) / den;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic logic [15:0] sigmoid_at(input longint x);
      longint          t;
      longint unsigned idx;
      t = x + 262144;
      idx = (t < 0) ? 0 : ((64'(t) * SIGMOID_TABLE_DEPTH) >> 19);
      if (idx > SIGMOID_TABLE_DEPTH - 1) begin
         idx = SIGMOID_TABLE_DEPTH - 1;
      end
      return sigmoid_table[idx];
   endfunction

   function automatic bit node_fits(input int i, input logic [15:0] amt);
      return node_live[i] && (17'(node_fill[i]) + 17'(amt) <= 17'(node_cap[i]));
   endfunction

   function automatic void reset_placement_state();
      for (int i = 0; i < NODE_COUNT; i++) begin
         node_cap[i] = '0;
         node_fill[i] = '0;
         node_comp[i] = '0;
         node_ret[i] = '0;
         node_live[i] = 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
         weight[k] = WEIGHT_RESET;
      end
      centre_offset = LOAD_THRESHOLD_RESET;
      usage_gain = PENALTY_GAIN_RESET;
   endfunction

   function automatic placement_type place_request(input request_type it);
      placement_type   res;
      longint unsigned cap_sum;
      longint unsigned fill_sum;
      longint unsigned s_sum;
      longint unsigned s [4];
      longint unsigned c;
      longint unsigned best;
      logic [15:0]     r;
      int              win;
      bit              have;
      res = '{default: '0};
      cap_sum = 0;
      fill_sum = 0;
      s_sum = 0;
      best = 0;
      win = 0;
      have = 0;
      case (it.mode)
         MODE_LOAD: begin
            node_cap[it.node_index] = it.amount;
            node_fill[it.node_index] = '0;
            node_comp[it.node_index] = it.comp_cost;
            node_ret[it.node_index] = it.ret_cost;
            node_live[it.node_index] = 1'b1;
         end
         MODE_SLOT: begin
            for (int i = 0; i < NODE_COUNT; i++) begin
               if (node_live[i]) begin
                  cap_sum += node_cap[i];
                  fill_sum += node_fill[i];
               end
            end
            r = sat_ratio(fill_sum, cap_sum);
            res.load_ratio = r;
            for (int k = 0; k < 4; k++) begin
               s[k] = sigmoid_at(longint'(r) - longint'(centre_offset)
                                 - longint'(SIG_OFFSET[k]));
               s_sum += s[k];
            end
            if (s_sum != 0) begin
               for (int k = 0; k < 4; k++) begin
                  c = (s[k] << 16) / s_sum;
                  weight[k] = c[15:0];
               end
            end
         end
         MODE_PREF: begin
            for (int i = 0; i < NODE_COUNT; i++) begin
               if (node_fits(i, it.amount)) begin
                  node_fill[i] = node_fill[i] + it.amount;
                  res.placed_mask[i] = 1'b1;
               end
            end
         end
         MODE_SCHED, MODE_XFER: begin
            for (int i = 0; i < NODE_COUNT; i++) begin
               if (node_fits(i, it.amount)) begin
                  if (it.mode == MODE_SCHED) begin
                     c = (64'(weight[0]) * node_comp[i] * it.amount) >> 20;
                     c += (64'(weight[1]) * node_ret[i]) >> 16;
                     c += (64'(weight[2]) * it.transfer_cost) >> 16;
                     c += (64'(weight[3]) * it.prep_cost) >> 16;
                  end else begin
                     r = sat_ratio(node_fill[i], node_cap[i]);
                     c = (64'(it.distance) << 12) + ((64'(usage_gain) * r) >> 16);
                  end
                  if (!have || c < best) begin
                     have = 1;
                     best = c;
                     win = i;
                  end
               end
            end
            if (have) begin
               node_fill[win] = node_fill[win] + it.amount;
               res.chosen_node = 3'(win);
               res.found = 1'b1;
               res.best_cost = (best > 64'(COST_MAX)) ? COST_MAX : best[27:0];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic send_item(input request_type it);
      int gap;
      bit took;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.mode <= it.mode;
      req.node_index <= it.node_index;
      req.amount <= it.amount;
      req.node_compute_cost <= it.comp_cost;
      req.node_retention_cost <= it.ret_cost;
      req.request_transfer_cost <= it.transfer_cost;
      req.request_prep_cost <= it.prep_cost;
      req.distance <= it.distance;
      req.valid <= 1'b1;
      do begin
         @(negedge clock);
         took = req.ready;
         @(posedge clock);
      end while (!took);
      expected_placements.push_back(place_request(it));
      items_sent++;
      mode_counts[it.mode]++;
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_placements.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_LOAD_THRESHOLD) begin
         centre_offset = value;
      end else begin
         usage_gain = value;
      end
      config_writes++;
   endtask

   function automatic request_type make_item(input logic [2:0] mode, input logic [2:0] idx,
                                             input logic [15:0] amt, input logic [15:0] cc,
                                             input logic [15:0] rc, input logic [15:0] tc,
                                             input logic [15:0] pc, input logic [15:0] dst);
      request_type it;
      it.mode = mode;
      it.node_index = idx;
      it.amount = amt;
      it.comp_cost = cc;
      it.ret_cost = rc;
      it.transfer_cost = tc;
      it.prep_cost = pc;
      it.distance = dst;
      return it;
   endfunction

   function automatic request_type random_item();
      request_type it;
      int          pick;
      it.node_index = 3'($urandom_range(0, 7));
      it.comp_cost = 16'($urandom);
      it.ret_cost = 16'($urandom);
      it.transfer_cost = 16'($urandom);
      it.prep_cost = 16'($urandom);
      it.distance = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         it.mode = MODE_LOAD;
      end else if (pick < 25) begin
         it.mode = MODE_SLOT;
      end else if (pick < 40) begin
         it.mode = MODE_PREF;
      end else if (pick < 68) begin
         it.mode = MODE_SCHED;
      end else if (pick < 95) begin
         it.mode = MODE_XFER;
      end else begin
         it.mode = 3'($urandom_range(MODE_XFER + 1, MODE_LAST));
      end
      if (it.mode == MODE_LOAD || $urandom_range(0, 9) == 0) begin
         it.amount = 16'($urandom);
      end else begin
         it.amount = 16'($urandom_range(0, 1500));
      end
      return it;
   endfunction

   task automatic test_directed();
      send_item(make_item(MODE_SCHED, 3'd0, 16'd10, 16'd0, 16'd0, 16'd5, 16'd5, 16'd0));
      send_item(make_item(MODE_XFER, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd9));
      send_item(make_item(MODE_SLOT, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_PREF, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      for (int m = MODE_XFER + 1; m <= MODE_LAST; m++) begin
         send_item(make_item(3'(m), 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF));
      end
      send_item(make_item(MODE_LOAD, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_LOAD, 3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_LOAD, 3'd3, 16'd100, 16'd200, 16'd300, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_PREF, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_PREF, 3'd0, 16'd60, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_SCHED, 3'd0, 16'd30, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0));
      send_item(make_item(MODE_XFER, 3'd0, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF));
      send_item(make_item(MODE_XFER, 3'd0, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_SLOT, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_LOAD, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_SCHED, 3'd0, 16'hFFF0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                          16'd0));
      send_item(make_item(MODE_SCHED, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_item(make_item(MODE_SLOT, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      wait_idle();
   endtask

   task automatic test_register_extremes();
      logic [15:0] thr_values [3] = '{16'd0, 16'hFFFF, 16'($urandom)};
      logic [15:0] gain_values [3] = '{16'hFFFF, 16'd0, 16'($urandom)};
      for (int p = 0; p < 3; p++) begin
         write_register(ADDR_LOAD_THRESHOLD, thr_values[p]);
         write_register(ADDR_PENALTY_GAIN, gain_values[p]);
         send_item(make_item(MODE_LOAD, 3'd2, 16'd400, 16'd1, 16'd2, 16'd0, 16'd0, 16'd0));
         send_item(make_item(MODE_PREF, 3'd0, 16'($urandom_range(0, 400)), 16'd0, 16'd0,
                             16'd0, 16'd0, 16'd0));
         send_item(make_item(MODE_SLOT, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
         send_item(make_item(MODE_XFER, 3'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
                             16'hFFFF));
         send_item(make_item(MODE_SCHED, 3'd0, 16'd1, 16'd0, 16'd0, 16'd7, 16'd9, 16'd0));
         wait_idle();
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) begin
            write_register(ADDR_LOAD_THRESHOLD, LOAD_THRESHOLD_RESET);
            write_register(ADDR_PENALTY_GAIN, PENALTY_GAIN_RESET);
         end else if (phase > 0) begin
            write_register(ADDR_LOAD_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                           16'($urandom) : 16'($urandom_range(0, 40000)));
            write_register(ADDR_PENALTY_GAIN, 16'($urandom));
         end
         for (int n = 0; n < 237; n++) begin
            if (n % 40 == 0) begin
               no_gaps = ($urandom_range(0, 3) == 0);
            end
            send_item(random_item());
         end
         no_gaps = 0;
         wait_idle();
      end
   endtask

   initial begin : receiver
      placement_type want;
      int            n;
      bit            got;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 15);
         if (n > 0) begin
            rsp.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do begin
            @(negedge clock);
            got = rsp.valid;
            if (got) begin
               if (expected_placements.size() == 0) begin
                  $error("result item arrived with no expectation pending");
                  errors++;
               end else begin
                  want = expected_placements.pop_front();
                  if (rsp.chosen_node !== want.chosen_node) begin
                     $error("chosen_node: expected %0d, got %0d", want.chosen_node,
                            rsp.chosen_node);
                     errors++;
                  end
                  if (rsp.found !== want.found) begin
                     $error("found: expected %0d, got %0d", want.found, rsp.found);
                     errors++;
                  end
                  if (rsp.best_cost !== want.best_cost) begin
                     $error("best_cost: expected %0d, got %0d", want.best_cost,
                            rsp.best_cost);
                     errors++;
                  end
                  if (rsp.placed_mask !== want.placed_mask) begin
                     $error("placed_mask: expected %02h, got %02h", want.placed_mask,
                            rsp.placed_mask);
                     errors++;
                  end
                  if (rsp.load_ratio !== want.load_ratio) begin
                     $error("load_ratio: expected %0d, got %0d", want.load_ratio,
                            rsp.load_ratio);
                     errors++;
                  end
                  if (want.found) begin
                     found_count++;
                  end
               end
               items_checked++;
            end
            @(posedge clock);
         end while (!got);
      end
   end

   initial begin : watchdog
      int quiet;
      int last_sent;
      int last_checked;
      quiet = 0;
      last_sent = 0;
      last_checked = 0;
      forever begin
         @(posedge clock);
         if (items_sent != last_sent || items_checked != last_checked) begin
            quiet = 0;
            last_sent = items_sent;
            last_checked = items_checked;
         end else begin
            quiet++;
         end
         if (quiet >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      items_sent = 0;
      items_checked = 0;
      found_count = 0;
      config_writes = 0;
      no_gaps = 0;
      foreach (mode_counts[m]) mode_counts[m] = 0;
      fill_sigmoid_table();
      reset_placement_state();
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req.valid <= 1'b0;
      req.mode <= MODE_LOAD;
      req.node_index <= '0;
      req.amount <= '0;
      req.node_compute_cost <= '0;
      req.node_retention_cost <= '0;
      req.request_transfer_cost <= '0;
      req.request_prep_cost <= '0;
      req.distance <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_traffic();
      $display("Checked %0d result items; %0d schedule or transfer requests were placed.",
               items_checked, found_count);
      $display("Items per kind: load %0d, slot %0d, prefetch %0d, schedule %0d, %s %0d, %s %0d.",
               mode_counts[MODE_LOAD], mode_counts[MODE_SLOT], mode_counts[MODE_PREF],
               mode_counts[MODE_SCHED], "transfer", mode_counts[MODE_XFER], "register writes",
               config_writes);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/wenp_pkg.sv
src/wenp_if.sv
src/wenp_csr.sv
src/wenp_ctrl.sv
src/wenp_datapath.sv
src/weighted_edge_node_placement.sv
src/wenp_checker.sv
bench/tb_weighted_edge_node_placement.sv
